// File: hw/rtl/cdq_pkg.sv
// cdq_pkg: shared constants, command codes and control/status types for the
// circular deque. No dependencies.
package cdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 16;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 2;
    localparam int OUT_RAW_W  = 1 + 2 * DATA_WIDTH + 2 + CNT_W;
    localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int IN_W       = ((DATA_WIDTH + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_REAR  = 2'd1,
        CMD_DEL_FRONT = 2'd2,
        CMD_DEL_REAR  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic load_cmd;
        logic exec;
        logic load_out;
    } ctrl_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/cdq_ram.sv
// cdq_ram: generic RAM, one write port and two registered read ports.
// No dependencies.
module cdq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: hw/rtl/cdq_ctrl.sv
// cdq_ctrl: sequencing state machine for the circular deque.
// Depends on cdq_pkg.
module cdq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cdq_pkg::status_t status,
    output cdq_pkg::ctrl_t   ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_READ = 4'b0100,
        ST_LOAD = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        ctrl.load_cmd = 1'b0;
        ctrl.exec     = 1'b0;
        ctrl.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load_cmd = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/cdq_dp.sv
// cdq_dp: deque datapath - pointers, count, capacity, store and result register.
// Depends on cdq_pkg and cdq_ram.
module cdq_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cdq_pkg::CNT_W-1:0]     cfg_wdata,
    input  logic [cdq_pkg::CMD_W-1:0]     in_cmd,
    input  logic [cdq_pkg::DATA_WIDTH-1:0] in_value,
    input  cdq_pkg::ctrl_t                ctrl,
    output cdq_pkg::status_t              status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cdq_pkg::OUT_W-1:0]     out_data
);

    localparam int PW = cdq_pkg::PTR_W;
    localparam int CW = cdq_pkg::CNT_W;
    localparam int DW = cdq_pkg::DATA_WIDTH;

    function automatic logic [PW-1:0] inc_wrap(input logic [PW-1:0] p,
                                               input logic [CW-1:0] cap);
        logic [CW:0] s;
        s = {1'b0, CW'(p)} + 1'b1;
        return (s >= {1'b0, cap}) ? '0 : s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] dec_wrap(input logic [PW-1:0] p,
                                               input logic [CW-1:0] cap);
        return (p == '0) ? PW'(cap - 1'b1) : p - 1'b1;
    endfunction

    cdq_pkg::cmd_t    cmd_reg;
    logic [DW-1:0]    value_reg;
    logic [PW-1:0]    front_reg, front_next;
    logic [PW-1:0]    rear_reg, rear_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic [CW-1:0]    cap_reg;
    logic             ok_reg, ok_next;
    logic             out_valid_reg;
    logic [cdq_pkg::OUT_W-1:0] out_data_reg;

    logic [CW-1:0]    cap_clamped;
    logic             wr_en;
    logic [PW-1:0]    wr_addr;
    logic [PW-1:0]    rd_rear_addr;
    logic [DW-1:0]    rd_front, rd_rear;
    logic [DW-1:0]    fv, rv;

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cap_clamped = CW'(1);
        end
        else if (cfg_wdata > CW'(cdq_pkg::DEPTH))
        begin
            cap_clamped = CW'(cdq_pkg::DEPTH);
        end
        else
        begin
            cap_clamped = cfg_wdata;
        end
    end

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        occ_next   = occ_reg;
        ok_next    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = rear_reg;
        case (cmd_reg)
            cdq_pkg::CMD_INS_FRONT:
            begin
                wr_addr = dec_wrap(front_reg, cap_reg);
                if (occ_reg < cap_reg)
                begin
                    ok_next    = 1'b1;
                    wr_en      = 1'b1;
                    front_next = wr_addr;
                    occ_next   = occ_reg + 1'b1;
                end
            end
            cdq_pkg::CMD_INS_REAR:
            begin
                if (occ_reg < cap_reg)
                begin
                    ok_next   = 1'b1;
                    wr_en     = 1'b1;
                    rear_next = inc_wrap(rear_reg, cap_reg);
                    occ_next  = occ_reg + 1'b1;
                end
            end
            cdq_pkg::CMD_DEL_FRONT:
            begin
                if (occ_reg != '0)
                begin
                    ok_next    = 1'b1;
                    front_next = inc_wrap(front_reg, cap_reg);
                    occ_next   = occ_reg - 1'b1;
                end
            end
            cdq_pkg::CMD_DEL_REAR:
            begin
                if (occ_reg != '0)
                begin
                    ok_next   = 1'b1;
                    rear_next = dec_wrap(rear_reg, cap_reg);
                    occ_next  = occ_reg - 1'b1;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            occ_reg   <= '0;
            cap_reg   <= CW'(cdq_pkg::DEPTH);
            ok_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            occ_reg   <= '0;
            cap_reg   <= cap_clamped;
        end
        else if (ctrl.exec)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            occ_reg   <= occ_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_cmd)
        begin
            cmd_reg   <= cdq_pkg::cmd_t'(in_cmd);
            value_reg <= in_value;
        end
    end

    assign rd_rear_addr = dec_wrap(rear_reg, cap_reg);

    cdq_ram #(
        .WIDTH (DW),
        .DEPTH (cdq_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ctrl.exec & wr_en),
        .waddr   (wr_addr),
        .wdata   (value_reg),
        .raddr_a (front_reg),
        .rdata_a (rd_front),
        .raddr_b (rd_rear_addr),
        .rdata_b (rd_rear)
    );

    assign fv = (occ_reg == '0) ? '0 : rd_front;
    assign rv = (occ_reg == '0) ? '0 : rd_rear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_data_reg <= cdq_pkg::OUT_W'({occ_reg,
                                             occ_reg == cap_reg,
                                             occ_reg == '0,
                                             rv, fv, ok_reg});
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

// File: hw/rtl/circular_deque.sv
// circular_deque: double-ended queue in a circular store, top level.
// Depends on cdq_pkg, cdq_ctrl, cdq_dp and cdq_ram.
// An accepted transaction passes the EXEC state (pointer update), the READ state
// (registered RAM read of the new front and rear words) and the LOAD state, which
// waits for a free output register; no new transaction is taken until LOAD ends.
// Reset: pointers and count cleared, capacity 16; store contents not cleared.
module circular_deque (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cdq_pkg::CNT_W-1:0]     cfg_wdata,     // capacity
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cdq_pkg::IN_W-1:0]      s_axis_tdata,  // value
    input  logic [cdq_pkg::CMD_W-1:0]     s_axis_tuser,  // command
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // success, front_value, rear_value, is_empty, is_full, entry_count
    output logic [cdq_pkg::OUT_W-1:0]     m_axis_tdata
);

    cdq_pkg::ctrl_t   ctrl;
    cdq_pkg::status_t status;

    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    cdq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (s_axis_tuser),
        .in_value  (s_axis_tdata[cdq_pkg::DATA_WIDTH-1:0]),
        .ctrl      (ctrl),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// File: hw/rtl/cdq_checker.sv
// cdq_checker: port-level assertions for circular_deque, bound to the top level.
// Depends on cdq_pkg.
module cdq_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [cdq_pkg::OUT_W-1:0]     m_axis_tdata
);

    localparam int DW   = cdq_pkg::DATA_WIDTH;
    localparam int CW   = cdq_pkg::CNT_W;
    localparam int E_B  = 1 + 2 * DW;
    localparam int C_LO = E_B + 2;

    logic [CW-1:0] cnt;
    logic          emp;
    logic [DW-1:0] fv, rv;

    assign cnt = m_axis_tdata[C_LO+CW-1:C_LO];
    assign emp = m_axis_tdata[E_B];
    assign fv  = m_axis_tdata[DW:1];
    assign rv  = m_axis_tdata[2*DW:DW+1];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction accepted while one is in progress");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (emp == (cnt == '0)))
        else $error("empty flag disagrees with entry count");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && emp |-> fv == '0 && rv == '0)
        else $error("non-zero words reported for an empty deque");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> cnt <= CW'(cdq_pkg::DEPTH))
        else $error("entry count beyond storage depth");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
